@@ rtl/core/cdg3_pkg.sv @@
// ----------------------------------------------------------------------------
// cdg3_pkg: shared types and constants for the 3D gradient stencil
// Grid limits, sample and result widths, register codes and the plane store
// address map used by the control and datapath modules.
// ----------------------------------------------------------------------------
package cdg3_pkg;

    // Sample and result widths (Q16.16 in, Q17.16 out)
    localparam int SAMPLE_BITS = 32;
    localparam int GRAD_BITS   = SAMPLE_BITS + 1;

    // Grid limits
    localparam int MAX_Y       = 64;
    localparam int MAX_Z       = 64;
    localparam int SX_BITS     = 16;
    localparam int SY_BITS     = $clog2(MAX_Y + 1);
    localparam int SZ_BITS     = $clog2(MAX_Z + 1);
    localparam int POS_Y_BITS  = $clog2(MAX_Y);
    localparam int POS_Z_BITS  = $clog2(MAX_Z);
    localparam int MIN_EXTENT  = 3;
    localparam int SIZE_RESET  = 64;

    // Plane store: two planes of MAX_Y * MAX_Z samples
    localparam int PLANE_CELLS = MAX_Y * MAX_Z;
    localparam int MEM_DEPTH   = 2 * PLANE_CELLS;
    localparam int ADDR_BITS   = $clog2(MEM_DEPTH);

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = SX_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } cfg_reg_t;

    // Per-beat control from the position counters to the datapath
    typedef struct packed {
        logic [ADDR_BITS-1:0] slot_addr;  // current cell, holds plane i-2
        logic [ADDR_BITS-1:0] ly_addr;    // plane i-1, row j-1
        logic [ADDR_BITS-1:0] uy_addr;    // plane i-1, row j+1
        logic [ADDR_BITS-1:0] zs_addr;    // plane i-1, z stream tap
        logic                 emit;
        logic                 last;
    } step_t;

    // Plane store address of (plane, y, z)
    function automatic logic [ADDR_BITS-1:0] cell_addr(
        input logic                  plane,
        input logic [POS_Y_BITS-1:0] y,
        input logic [POS_Z_BITS-1:0] z
    );
        logic [ADDR_BITS-1:0] a;
        a = ADDR_BITS'(plane) * ADDR_BITS'(PLANE_CELLS)
          + ADDR_BITS'(y) * ADDR_BITS'(MAX_Z)
          + ADDR_BITS'(z);
        return a;
    endfunction

endpackage

@@ rtl/core/cdg3_ram.sv @@
// ----------------------------------------------------------------------------
// cdg3_ram: generic one-write, two-read synchronous RAM
// Read data is registered and only updates when the read enable is high; a
// read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module cdg3_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read before write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

@@ rtl/core/cdg3_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdg3_ctrl: extent registers, raster position counters, address generation
// Tracks the (x, y, z) position of the next sample, decides whether the beat
// closes an interior point and builds the plane store addresses.
// ----------------------------------------------------------------------------
module cdg3_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cdg3_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cdg3_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                             accept,
    output cdg3_pkg::step_t                  step
);

    logic [cdg3_pkg::SX_BITS-1:0]    size_x_reg, size_x_next;
    logic [cdg3_pkg::SY_BITS-1:0]    size_y_reg, size_y_next;
    logic [cdg3_pkg::SZ_BITS-1:0]    size_z_reg, size_z_next;
    logic [cdg3_pkg::SX_BITS-1:0]    pos_x_reg, pos_x_next;
    logic [cdg3_pkg::POS_Y_BITS-1:0] pos_y_reg, pos_y_next;
    logic [cdg3_pkg::POS_Z_BITS-1:0] pos_z_reg, pos_z_next;

    logic [cdg3_pkg::SX_BITS-1:0] sx_use;
    logic [cdg3_pkg::SY_BITS-1:0] sy_use;
    logic [cdg3_pkg::SZ_BITS-1:0] sz_use;
    logic [cdg3_pkg::SY_BITS-1:0] j_ext;
    logic [cdg3_pkg::SZ_BITS-1:0] k_ext;
    logic [cdg3_pkg::SX_BITS:0]   i_inc;
    logic                         x_end, y_end, z_end;
    logic                         interior;
    logic                         prev_plane;

    // Extents in use, clamped to the supported range
    always_comb
    begin
        sx_use = size_x_reg;
        if (size_x_reg < cdg3_pkg::SX_BITS'(cdg3_pkg::MIN_EXTENT))
        begin
            sx_use = cdg3_pkg::SX_BITS'(cdg3_pkg::MIN_EXTENT);
        end
        sy_use = size_y_reg;
        if (size_y_reg < cdg3_pkg::SY_BITS'(cdg3_pkg::MIN_EXTENT))
        begin
            sy_use = cdg3_pkg::SY_BITS'(cdg3_pkg::MIN_EXTENT);
        end
        else if (size_y_reg > cdg3_pkg::SY_BITS'(cdg3_pkg::MAX_Y))
        begin
            sy_use = cdg3_pkg::SY_BITS'(cdg3_pkg::MAX_Y);
        end
        sz_use = size_z_reg;
        if (size_z_reg < cdg3_pkg::SZ_BITS'(cdg3_pkg::MIN_EXTENT))
        begin
            sz_use = cdg3_pkg::SZ_BITS'(cdg3_pkg::MIN_EXTENT);
        end
        else if (size_z_reg > cdg3_pkg::SZ_BITS'(cdg3_pkg::MAX_Z))
        begin
            sz_use = cdg3_pkg::SZ_BITS'(cdg3_pkg::MAX_Z);
        end
    end

    // Row, column and volume ends
    assign j_ext = cdg3_pkg::SY_BITS'(pos_y_reg);
    assign k_ext = cdg3_pkg::SZ_BITS'(pos_z_reg);
    assign i_inc = (cdg3_pkg::SX_BITS + 1)'(pos_x_reg) + 1'b1;
    assign z_end = (k_ext + 1'b1) >= sz_use;
    assign y_end = (j_ext + 1'b1) >= sy_use;
    assign x_end = i_inc >= (cdg3_pkg::SX_BITS + 1)'(sx_use);

    // Interior test for the point one plane back
    assign interior = (pos_x_reg >= cdg3_pkg::SX_BITS'(2))
                   && (pos_y_reg != '0) && ((j_ext + 2'd2) <= sy_use)
                   && (pos_z_reg != '0) && ((k_ext + 2'd2) <= sz_use);

    assign prev_plane = ~pos_x_reg[0];

    // Addresses and flags for this beat; the z stream tap reads (j, k+1),
    // and at the row end it reads the head of the next row so that the
    // two-beat delayed copy supplies the lower z neighbor at k = 1.
    always_comb
    begin
        step.slot_addr = cdg3_pkg::cell_addr(pos_x_reg[0], pos_y_reg, pos_z_reg);
        step.ly_addr   = cdg3_pkg::cell_addr(prev_plane, pos_y_reg - 1'b1, pos_z_reg);
        step.uy_addr   = cdg3_pkg::cell_addr(prev_plane, pos_y_reg + 1'b1, pos_z_reg);
        if (z_end)
        begin
            step.zs_addr = cdg3_pkg::cell_addr(prev_plane, pos_y_reg + 1'b1, '0);
        end
        else
        begin
            step.zs_addr = cdg3_pkg::cell_addr(prev_plane, pos_y_reg, pos_z_reg + 1'b1);
        end
        step.emit = interior;
        step.last = interior && (i_inc == (cdg3_pkg::SX_BITS + 1)'(sx_use))
                 && ((j_ext + 2'd2) == sy_use) && ((k_ext + 2'd2) == sz_use);
    end

    // Register writes and counter advance
    always_comb
    begin
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        size_z_next = size_z_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        pos_z_next  = pos_z_reg;
        if (accept)
        begin
            if (z_end)
            begin
                pos_z_next = '0;
                if (y_end)
                begin
                    pos_y_next = '0;
                    pos_x_next = x_end ? '0 : i_inc[cdg3_pkg::SX_BITS-1:0];
                end
                else
                begin
                    pos_y_next = pos_y_reg + 1'b1;
                end
            end
            else
            begin
                pos_z_next = pos_z_reg + 1'b1;
            end
        end
        if (cfg_we)
        begin
            case (cfg_index)
                cdg3_pkg::REG_SIZE_X:
                begin
                    size_x_next = cfg_data[cdg3_pkg::SX_BITS-1:0];
                    pos_x_next  = '0;
                    pos_y_next  = '0;
                    pos_z_next  = '0;
                end
                cdg3_pkg::REG_SIZE_Y:
                begin
                    size_y_next = cfg_data[cdg3_pkg::SY_BITS-1:0];
                    pos_x_next  = '0;
                    pos_y_next  = '0;
                    pos_z_next  = '0;
                end
                cdg3_pkg::REG_SIZE_Z:
                begin
                    size_z_next = cfg_data[cdg3_pkg::SZ_BITS-1:0];
                    pos_x_next  = '0;
                    pos_y_next  = '0;
                    pos_z_next  = '0;
                end
                default:
                begin
                    size_x_next = size_x_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= cdg3_pkg::SX_BITS'(cdg3_pkg::SIZE_RESET);
            size_y_reg <= cdg3_pkg::SY_BITS'(cdg3_pkg::SIZE_RESET);
            size_z_reg <= cdg3_pkg::SZ_BITS'(cdg3_pkg::SIZE_RESET);
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
        end
        else
        begin
            size_x_reg <= size_x_next;
            size_y_reg <= size_y_next;
            size_z_reg <= size_z_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
        end
    end

    // Position always inside the extents in use, also across register writes
    a_pos_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_x_reg < sx_use)
        else $error("x position beyond extent");

    a_pos_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        j_ext < sy_use)
        else $error("y position beyond extent");

    a_pos_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_ext < sz_use)
        else $error("z position beyond extent");

endmodule

@@ rtl/core/cdg3_diff.sv @@
// ----------------------------------------------------------------------------
// cdg3_diff: difference stage and result register
// Holds the current sample beside the registered plane store reads, keeps a
// two-beat delay of the z stream tap and forms the three differences.
// ----------------------------------------------------------------------------
module cdg3_diff (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                emit,
    input  logic                                last_in,
    input  logic signed [cdg3_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [cdg3_pkg::SAMPLE_BITS-1:0]    lx_rdata,
    input  logic [cdg3_pkg::SAMPLE_BITS-1:0]    ly_rdata,
    input  logic [cdg3_pkg::SAMPLE_BITS-1:0]    uy_rdata,
    input  logic [cdg3_pkg::SAMPLE_BITS-1:0]    zs_rdata,
    output logic                                in_stall,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [cdg3_pkg::GRAD_BITS-1:0] grad_x,
    output logic signed [cdg3_pkg::GRAD_BITS-1:0] grad_y,
    output logic signed [cdg3_pkg::GRAD_BITS-1:0] grad_z,
    output logic                                last
);

    logic                                s1_emit_reg, s1_emit_next;
    logic                                s1_last_reg;
    logic [cdg3_pkg::SAMPLE_BITS-1:0]    cur_reg;
    logic [cdg3_pkg::SAMPLE_BITS-1:0]    zs_d1_reg;
    logic [cdg3_pkg::SAMPLE_BITS-1:0]    zs_d2_reg;
    logic                                out_valid_reg, out_valid_next;
    logic signed [cdg3_pkg::GRAD_BITS-1:0] grad_x_reg, grad_y_reg, grad_z_reg;
    logic                                last_reg;
    logic signed [cdg3_pkg::GRAD_BITS-1:0] dx, dy, dz;
    logic                                out_ready;
    logic                                load_out;

    // Handshake between stage 1 and the result register
    assign out_ready = !out_valid_reg || !out_stall;
    assign in_stall  = s1_emit_reg && !out_ready;
    assign load_out  = s1_emit_reg && out_ready;

    // Exact differences, lower minus upper, one bit wider than a sample
    assign dx = $signed({lx_rdata[cdg3_pkg::SAMPLE_BITS-1], lx_rdata})
              - $signed({cur_reg[cdg3_pkg::SAMPLE_BITS-1], cur_reg});
    assign dy = $signed({ly_rdata[cdg3_pkg::SAMPLE_BITS-1], ly_rdata})
              - $signed({uy_rdata[cdg3_pkg::SAMPLE_BITS-1], uy_rdata});
    assign dz = $signed({zs_d2_reg[cdg3_pkg::SAMPLE_BITS-1], zs_d2_reg})
              - $signed({zs_rdata[cdg3_pkg::SAMPLE_BITS-1], zs_rdata});

    // Stage 1 occupancy and result valid
    always_comb
    begin
        s1_emit_next = s1_emit_reg;
        if (accept)
        begin
            s1_emit_next = emit;
        end
        else if (out_ready)
        begin
            s1_emit_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = s1_emit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_emit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_emit_reg   <= s1_emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload and z stream delay, shifted once per accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg     <= sample;
            s1_last_reg <= last_in;
            zs_d1_reg   <= zs_rdata;
            zs_d2_reg   <= zs_d1_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            grad_x_reg <= dx;
            grad_y_reg <= dy;
            grad_z_reg <= dz;
            last_reg   <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign grad_x    = grad_x_reg;
    assign grad_y    = grad_y_reg;
    assign grad_z    = grad_z_reg;
    assign last      = last_reg;

    // A pending result in stage 1 is never dropped while the output is blocked
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit_reg && !out_ready |=> s1_emit_reg)
        else $error("stage 1 result lost");

    // A taken result is not shown again unless a new one was waiting
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !s1_emit_reg |=> !out_valid_reg)
        else $error("result repeated");

    // A stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(grad_x_reg)
            && $stable(grad_y_reg) && $stable(grad_z_reg) && $stable(last_reg))
        else $error("stalled result changed");

endmodule

@@ rtl/core/central_difference_gradient_3d.sv @@
// ----------------------------------------------------------------------------
// central_difference_gradient_3d: streaming 3D central difference stencil
// Takes one Q16.16 sample per beat in raster order and returns the negated
// unhalved central difference of each interior point, one plane behind.
// ----------------------------------------------------------------------------
// One sample is taken every cycle unless the result side stalls the input;
// the plane store reads and the sample that completes an interior point are
// registered, then its differences go to the result register. The rate
// is set by the plane store, held as two copies of 2 x 64 x 64 samples with
// one write and two registered reads each, so four neighbors come out per
// beat; the lower z neighbor is a two-beat delayed copy of the upper z read.
// The store has no clearing pass and needs none: every entry the block uses
// is written earlier in the same volume. Any register write must be made
// while the block is idle; a size write restarts the volume at position zero.
// ----------------------------------------------------------------------------
module central_difference_gradient_3d (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [cdg3_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [cdg3_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [cdg3_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [cdg3_pkg::GRAD_BITS-1:0]   grad_x,
    output logic signed [cdg3_pkg::GRAD_BITS-1:0]   grad_y,
    output logic signed [cdg3_pkg::GRAD_BITS-1:0]   grad_z,
    output logic                                    last
);

    cdg3_pkg::step_t                  step;
    logic                             accept;
    logic [cdg3_pkg::SAMPLE_BITS-1:0] lx_rdata, ly_rdata, uy_rdata, zs_rdata;

    assign accept = in_valid && !in_stall;

    // Position counters and addresses
    cdg3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .step      (step)
    );

    // Plane store, copy A: plane i-2 at the current cell and row j+1
    cdg3_ram #(
        .DEPTH (cdg3_pkg::MEM_DEPTH),
        .WIDTH (cdg3_pkg::SAMPLE_BITS)
    ) u_store_a (
        .clk     (clk),
        .we      (accept),
        .waddr   (step.slot_addr),
        .wdata   (sample),
        .re      (accept),
        .raddr_a (step.slot_addr),
        .raddr_b (step.uy_addr),
        .rdata_a (lx_rdata),
        .rdata_b (uy_rdata)
    );

    // Plane store, copy B: row j-1 and the z stream tap
    cdg3_ram #(
        .DEPTH (cdg3_pkg::MEM_DEPTH),
        .WIDTH (cdg3_pkg::SAMPLE_BITS)
    ) u_store_b (
        .clk     (clk),
        .we      (accept),
        .waddr   (step.slot_addr),
        .wdata   (sample),
        .re      (accept),
        .raddr_a (step.ly_addr),
        .raddr_b (step.zs_addr),
        .rdata_a (ly_rdata),
        .rdata_b (zs_rdata)
    );

    // Differences and result register
    cdg3_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .emit      (step.emit),
        .last_in   (step.last),
        .sample    (sample),
        .lx_rdata  (lx_rdata),
        .ly_rdata  (ly_rdata),
        .uy_rdata  (uy_rdata),
        .zs_rdata  (zs_rdata),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .grad_z    (grad_z),
        .last      (last)
    );

endmodule

@@ tb/sv/central_difference_gradient_3d_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// central_difference_gradient_3d_test: self-checking bench for the 3D stencil
// Streams raster-ordered Q16.16 grids through the block under random idling
// on both sides. An in-bench predictor tracks the extents, the position and
// two x-planes of samples; results are checked against it or the table.
// ----------------------------------------------------------------------------
module central_difference_gradient_3d_test;

    // Expected gradient of one interior point
    typedef struct packed {
        logic signed [cdg3_pkg::GRAD_BITS-1:0] gx;
        logic signed [cdg3_pkg::GRAD_BITS-1:0] gy;
        logic signed [cdg3_pkg::GRAD_BITS-1:0] gz;
        logic                                  last_pt;
    } grad_t;

    // One row of the directed table: sample, and a typed-in result if any
    typedef struct packed {
        logic [cdg3_pkg::SAMPLE_BITS-1:0] value;
        logic                             typed;
        grad_t                            want;
    } stim_row_t;

    localparam logic [cdg3_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 37;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_ITEMS    = 450;
    localparam int DIRECTED_LEN   = 27;

    // 3x3x3 volume, index = x*9 + y*3 + z. Only (2,1,1) yields a point:
    // the center (1,1,1) with full-scale x and y differences and last set.
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{32'h0000_0000, 1'b0, '0},
        '{32'h0001_0000, 1'b0, '0},
        '{32'hFFFF_0000, 1'b0, '0},
        '{32'h1234_5678, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0},   // (0,1,1) lower x neighbor
        '{32'h8000_0001, 1'b0, '0},
        '{32'h0000_0001, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},   // (1,0,1) lower y neighbor
        '{32'h0F0F_0F0F, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0},   // (1,1,0) lower z neighbor
        '{32'h7FFF_FFFF, 1'b0, '0},
        '{32'h0001_0000, 1'b0, '0},   // (1,1,2) upper z neighbor
        '{32'hF0F0_F0F0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0},   // (1,2,1) upper y neighbor
        '{32'h0000_8000, 1'b0, '0},
        '{32'hC000_0000, 1'b0, '0},
        '{32'h3FFF_FFFF, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h0000_0002, 1'b0, '0},
        '{32'h8000_0000, 1'b1,        // (2,1,1) upper x neighbor
          '{33'h0_FFFF_FFFF, 33'h1_0000_0001, 33'h1_FFFF_0000, 1'b1}},
        '{32'h7FFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0},
        '{32'h0001_0000, 1'b0, '0}
    };

    logic                                    clk       = 1'b0;
    logic                                    rst_n     = 1'b0;
    logic                                    cfg_we    = 1'b0;
    logic [cdg3_pkg::CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [cdg3_pkg::CFG_DATA_BITS-1:0]      cfg_data  = '0;
    logic                                    in_valid  = 1'b0;
    logic                                    in_stall;
    logic signed [cdg3_pkg::SAMPLE_BITS-1:0] sample    = '0;
    logic                                    out_valid;
    logic                                    out_stall = 1'b0;
    logic signed [cdg3_pkg::GRAD_BITS-1:0]   grad_x;
    logic signed [cdg3_pkg::GRAD_BITS-1:0]   grad_y;
    logic signed [cdg3_pkg::GRAD_BITS-1:0]   grad_z;
    logic                                    last;

    // Predictor state: extents as written, next position, two x-planes
    logic [cdg3_pkg::SX_BITS-1:0] ext_x = cdg3_pkg::SX_BITS'(cdg3_pkg::SIZE_RESET);
    logic [cdg3_pkg::SY_BITS-1:0] ext_y = cdg3_pkg::SY_BITS'(cdg3_pkg::SIZE_RESET);
    logic [cdg3_pkg::SZ_BITS-1:0] ext_z = cdg3_pkg::SZ_BITS'(cdg3_pkg::SIZE_RESET);
    int unsigned                  at_x  = 0;
    int unsigned                  at_y  = 0;
    int unsigned                  at_z  = 0;
    logic signed [cdg3_pkg::SAMPLE_BITS-1:0] plane_mem [2][cdg3_pkg::MAX_Y][cdg3_pkg::MAX_Z];

    grad_t grad_q [$];
    bit    steady          = 1'b0;   // no idling on either side
    int    mismatches      = 0;
    int    samples_sent    = 0;
    int    grads_expected  = 0;
    int    grads_checked   = 0;
    int    volumes_closed  = 0;
    int    settings_used   = 0;
    int    quiet_cycles    = 0;

    central_difference_gradient_3d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .grad_z    (grad_z),
        .last      (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_extent(input int unsigned v, input int unsigned hi);
        if (v < cdg3_pkg::MIN_EXTENT)
            return cdg3_pkg::MIN_EXTENT;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the predictor by one sample; returns 1 when a point is due
    function automatic bit step_gradient(input logic signed [cdg3_pkg::SAMPLE_BITS-1:0] cur,
                                         output grad_t g);
        int unsigned                             ex, ey, ez, p;
        bit                                      hit;
        logic signed [cdg3_pkg::SAMPLE_BITS-1:0] lx, ly, uy, lz, uz;
        ex  = clamp_extent(32'(ext_x), 65535);
        ey  = clamp_extent(32'(ext_y), cdg3_pkg::MAX_Y);
        ez  = clamp_extent(32'(ext_z), cdg3_pkg::MAX_Z);
        hit = at_x >= 2 && at_y >= 1 && at_y + 2 <= ey && at_z >= 1 && at_z + 2 <= ez;
        g   = '0;
        if (hit)
        begin
            p  = at_x - 1;
            // plane i-2 sits in the slot the current sample overwrites
            lx = plane_mem[at_x % 2][at_y][at_z];
            ly = plane_mem[p % 2][at_y - 1][at_z];
            uy = plane_mem[p % 2][at_y + 1][at_z];
            lz = plane_mem[p % 2][at_y][at_z - 1];
            uz = plane_mem[p % 2][at_y][at_z + 1];
            g.gx      = {lx[cdg3_pkg::SAMPLE_BITS-1], lx} - {cur[cdg3_pkg::SAMPLE_BITS-1], cur};
            g.gy      = {ly[cdg3_pkg::SAMPLE_BITS-1], ly} - {uy[cdg3_pkg::SAMPLE_BITS-1], uy};
            g.gz      = {lz[cdg3_pkg::SAMPLE_BITS-1], lz} - {uz[cdg3_pkg::SAMPLE_BITS-1], uz};
            g.last_pt = (p + 2 == ex) && (at_y + 2 == ey) && (at_z + 2 == ez);
        end
        plane_mem[at_x % 2][at_y][at_z] = cur;

        // raster order, z fastest, wrap at end of volume
        if (at_z + 1 >= ez)
        begin
            at_z = 0;
            if (at_y + 1 >= ey)
            begin
                at_y = 0;
                at_x = (at_x + 1 >= ex) ? 0 : at_x + 1;
            end
            else
                at_y = at_y + 1;
        end
        else
            at_z = at_z + 1;
        return hit;
    endfunction

    // Register write; a known index restarts the volume
    task automatic write_reg(input logic [cdg3_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [cdg3_pkg::CFG_DATA_BITS-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            cdg3_pkg::REG_SIZE_X: ext_x = d;
            cdg3_pkg::REG_SIZE_Y: ext_y = d[cdg3_pkg::SY_BITS-1:0];
            cdg3_pkg::REG_SIZE_Z: ext_z = d[cdg3_pkg::SZ_BITS-1:0];
            default:              return;
        endcase
        at_x = 0;
        at_y = 0;
        at_z = 0;
    endtask

    task automatic load_extents(input logic [cdg3_pkg::CFG_DATA_BITS-1:0] sx, sy, sz,
                                input bit with_unused);
        if (with_unused)
            write_reg(REG_UNUSED, cdg3_pkg::CFG_DATA_BITS'($urandom));
        write_reg(cdg3_pkg::REG_SIZE_X, sx);
        write_reg(cdg3_pkg::REG_SIZE_Y, sy);
        write_reg(cdg3_pkg::REG_SIZE_Z, sz);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // One input beat, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [cdg3_pkg::SAMPLE_BITS-1:0] v,
                               input logic typed, input grad_t typed_want);
        grad_t g;
        bit    hit;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = step_gradient(v, g);
        if (typed)
            grad_q.push_back(typed_want);
        else if (hit)
            grad_q.push_back(g);
        if (typed || hit)
            grads_expected++;
        samples_sent++;
    endtask

    // Idle the input and let the pipeline empty before touching registers
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (grad_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void report_field(input string name,
                                         input logic signed [cdg3_pkg::GRAD_BITS-1:0] want,
                                         got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
    endfunction

    // Result side stall
    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Compare each result beat with the oldest expected gradient
    always @(posedge clk)
    begin : check_gradients
        grad_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (grad_q.size() == 0)
            begin
                $display("%0t: result beat, expected none, got x=%0d y=%0d z=%0d last=%0b",
                         $time, grad_x, grad_y, grad_z, last);
                mismatches++;
            end
            else
            begin
                want = grad_q.pop_front();
                if (grad_x !== want.gx)
                    report_field("grad_x", want.gx, grad_x);
                if (grad_y !== want.gy)
                    report_field("grad_y", want.gy, grad_y);
                if (grad_z !== want.gz)
                    report_field("grad_z", want.gz, grad_z);
                if (last !== want.last_pt)
                    report_field("last", cdg3_pkg::GRAD_BITS'(want.last_pt),
                                 cdg3_pkg::GRAD_BITS'(last));
                grads_checked++;
                if (want.last_pt)
                    volumes_closed++;
            end
        end
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned                             phase_no, count, vol, sel;
        logic [cdg3_pkg::CFG_DATA_BITS-1:0]      sx, sy, sz;
        logic signed [cdg3_pkg::SAMPLE_BITS-1:0] v;
        phase_no = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: smallest volume, extents clamped up from 0 and 2, z masked
        load_extents(16'd0, 16'd2, 16'h0083, 1'b1);
        for (int n = 0; n < DIRECTED_LEN; n++)
            send_sample(DIRECTED_ROWS[n].value, DIRECTED_ROWS[n].typed,
                        DIRECTED_ROWS[n].want);
        wait_drained();

        // Random phases of mostly small volumes; one phase runs with no idling
        while (samples_sent < TOTAL_ITEMS)
        begin
            steady = (phase_no == 2);
            sel    = steady ? 9 : $urandom_range(0, 9);
            case (sel)
                0:
                begin
                    // unknown index only: the volume carries on
                    write_reg(REG_UNUSED, cdg3_pkg::CFG_DATA_BITS'($urandom));
                    cfg_we <= 1'b0;
                    count = $urandom_range(1, 60);
                end
                1:
                begin
                    // very long x, only the first planes are streamed
                    sx = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1000, 65534));
                    load_extents(sx, 16'($urandom_range(3, 4)), 16'($urandom_range(3, 4)),
                                 1'($urandom_range(0, 1)));
                    count = $urandom_range(20, 60);
                end
                2:
                begin
                    // all extents below the minimum
                    load_extents(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                                 16'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
                    count = 27 * $urandom_range(1, 3);
                end
                3:
                begin
                    // y or z written above the maximum so it clamps
                    if ($urandom_range(0, 1))
                        load_extents(16'($urandom_range(3, 6)), 16'($urandom_range(65, 127)),
                                     16'd3, 1'($urandom_range(0, 1)));
                    else
                        load_extents(16'($urandom_range(3, 6)), 16'd3,
                                     16'($urandom_range(65, 127)), 1'($urandom_range(0, 1)));
                    count = $urandom_range(20, 60);
                end
                default:
                begin
                    // small volume; unused upper bits of y and z set at times
                    sy = 16'($urandom_range(3, 6));
                    sz = 16'($urandom_range(3, 6));
                    if ($urandom_range(0, 1))
                    begin
                        sy = sy | (16'($urandom) & 16'hFF80);
                        sz = sz | (16'($urandom) & 16'hFF80);
                    end
                    load_extents(16'($urandom_range(3, 6)), sy, sz, $urandom_range(0, 3) == 0);
                    vol   = clamp_extent(32'(ext_x), 65535)
                          * clamp_extent(32'(ext_y), cdg3_pkg::MAX_Y)
                          * clamp_extent(32'(ext_z), cdg3_pkg::MAX_Z);
                    if (steady)
                        count = vol * 2;
                    else
                        count = $urandom_range(0, 1) ? vol : $urandom_range(1, vol);
                end
            endcase
            if (count > TOTAL_ITEMS - samples_sent)
                count = TOTAL_ITEMS - samples_sent;

            for (int n = 0; n < count; n++)
            begin
                case ($urandom_range(0, 7))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = $urandom_range(0, 511) - 256;
                    default: v = $urandom;
                endcase
                send_sample(v, 1'b0, '0);
            end
            wait_drained();
            phase_no++;
        end
        steady = 1'b0;

        $display("Streamed %0d samples through %0d extent settings in %0d random phases.",
                 samples_sent, settings_used, phase_no);
        $display("Checked %0d gradients, %0d of them volume ends; %0d mismatches.",
                 grads_checked, volumes_closed, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/cdg3_pkg.sv
rtl/core/cdg3_ram.sv
rtl/core/cdg3_ctrl.sv
rtl/core/cdg3_diff.sv
rtl/core/central_difference_gradient_3d.sv
tb/sv/central_difference_gradient_3d_test.sv
